@@ hdl/slcd_pkg.sv @@
// Shared constants, command decode type and frame helpers for the segment LCD frame shifter.
package slcd_pkg;

   localparam int PIN_COUNT = 240;
   localparam int POS_W     = $clog2(PIN_COUNT);
   localparam int SEG_W     = 8;
   localparam int MODE_W    = 3;
   localparam int HALF_W    = 16;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [MODE_W-1:0] MODE_SET_SEG = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CLR_SEG = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FILL    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FLUSH   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_TICK    = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_ON = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FR_HALF    = 1'd1;

   localparam logic [HALF_W-1:0] FR_HALF_RESET = 16'd500;

   // Fill pattern: every segment on, common and unconnected pins low.
   localparam logic [PIN_COUNT-1:0] FILL_MASK = {{(PIN_COUNT-2){1'b1}}, 2'b00};

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(PIN_COUNT - 1);

   typedef struct packed {
      logic             set_seg;
      logic             clr_seg;
      logic             fill;
      logic             clear;
      logic             flush;
      logic             tick;
      logic [SEG_W-1:0] segment;
   } cmd_type;

   typedef struct packed {
      logic serial_data;
      logic shift_strobe;
      logic last_bit;
      logic busy;
   } shift_type;

endpackage

@@ hdl/slcd_frame.sv @@
// Frame bit store with segment write decode and the serial flush shifter.
module slcd_frame (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  slcd_pkg::cmd_type    cmd,
   output slcd_pkg::shift_type  shift_out
);

   logic [slcd_pkg::PIN_COUNT-1:0] frame_ff, frame_in;
   logic [slcd_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic                           shifting_ff, shifting_in;
   logic [slcd_pkg::SEG_W:0]       seg_wide;
   logic [slcd_pkg::SEG_W:0]       set_pos_wide;
   logic                           seg_ok;
   logic                           is_last;

   assign seg_wide     = {1'b0, cmd.segment};
   assign seg_ok       = (seg_wide != '0) &&
                         (seg_wide <= (slcd_pkg::SEG_W+1)'(slcd_pkg::PIN_COUNT));
   assign set_pos_wide = (slcd_pkg::SEG_W+1)'(slcd_pkg::PIN_COUNT) - seg_wide;
   assign is_last      = (pos_ff >= slcd_pkg::LAST_POS);

   always_comb begin
      frame_in    = frame_ff;
      pos_in      = pos_ff;
      shifting_in = shifting_ff;
      shift_out   = '0;
      if (step) begin
         if ((cmd.set_seg || cmd.clr_seg) && seg_ok) begin
            frame_in[set_pos_wide[slcd_pkg::POS_W-1:0]] = cmd.set_seg;
            frame_in[1:0] = 2'b00;
         end
         if (cmd.fill) begin
            frame_in = slcd_pkg::FILL_MASK;
         end
         if (cmd.clear) begin
            frame_in = '0;
         end
         if (cmd.flush) begin
            shifting_in = 1'b1;
            pos_in      = '0;
         end
         // Shift one bit per tick; wrap and drop busy after the last pin.
         if (cmd.tick && shifting_ff) begin
            shift_out.serial_data  = frame_ff[pos_ff];
            shift_out.shift_strobe = 1'b1;
            if (is_last) begin
               shift_out.last_bit = 1'b1;
               shifting_in        = 1'b0;
               pos_in             = '0;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end
      shift_out.busy = shifting_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff    <= '0;
         pos_ff      <= '0;
         shifting_ff <= 1'b0;
      end else begin
         frame_ff    <= frame_in;
         pos_ff      <= pos_in;
         shifting_ff <= shifting_in;
      end
   end

endmodule

@@ hdl/slcd_fr.sv @@
// Frame reversal square wave timer driven by ticks.
module slcd_fr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        tick,
   input  logic                        display_on,
   input  logic                        cfg_clear,
   input  logic [slcd_pkg::HALF_W-1:0] half_period,
   output logic                        fr_level
);

   logic [slcd_pkg::HALF_W-1:0] count_ff, count_in;
   logic                        state_ff, state_in;
   logic [slcd_pkg::HALF_W:0]   count_inc;

   assign count_inc = {1'b0, count_ff} + 1'b1;

   always_comb begin
      count_in = count_ff;
      state_in = state_ff;
      if (cfg_clear) begin
         count_in = '0;
         state_in = 1'b0;
      end else if (tick) begin
         if (display_on) begin
            // Toggle once the half period is reached; zero acts as one.
            if (count_inc >= {1'b0, half_period}) begin
               count_in = '0;
               state_in = !state_ff;
            end else begin
               count_in = count_inc[slcd_pkg::HALF_W-1:0];
            end
         end else begin
            count_in = '0;
            state_in = 1'b0;
         end
      end
   end

   assign fr_level = state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         state_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/segment_lcd_frame_shifter.sv @@
// Top level of the segment LCD frame shifter: input register, frame and timer, result register.
//
// Each request beat is captured in an input register and processed when the
// result register is free: the frame store, flush shifter and frame reversal
// timer update together and the response beat is loaded into a result
// register. One beat is accepted every cycle while the response side takes
// results. A stall on rsp_ready holds the result register and the input
// register, so req_ready drops only when both are full. Set and clear use
// segment numbers 1..240; pins 0 and 1 (common and unconnected) always read
// zero. Configuration writes land at once and must be made with no beat in
// flight.
module segment_lcd_frame_shifter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [slcd_pkg::MODE_W-1:0]    req_mode,
   input  logic [slcd_pkg::SEG_W-1:0]     req_segment,
   input  logic                           req_seg_on,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_serial_data,
   output logic                           rsp_shift_strobe,
   output logic                           rsp_last_bit,
   output logic                           rsp_fr_level,
   output logic                           rsp_disp_level,
   output logic                           rsp_busy_res,
   input  logic                           csr_we,
   input  logic [slcd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [slcd_pkg::CSR_W-1:0]     csr_wdata
);

   logic                          in_valid_ff;
   logic [slcd_pkg::MODE_W-1:0]   in_mode_ff;
   logic [slcd_pkg::SEG_W-1:0]    in_segment_ff;
   logic                          in_seg_on_ff;
   logic                          out_valid_ff, out_valid_in;
   logic                          out_data_ff, out_strobe_ff, out_last_ff;
   logic                          out_fr_ff, out_disp_ff, out_busy_ff;
   logic                          display_on_ff;
   logic [slcd_pkg::HALF_W-1:0]   half_period_ff;
   logic                          advance;
   logic                          out_free;
   logic                          req_take;
   logic                          fr_clear;
   logic                          fr_level;
   slcd_pkg::cmd_type             cmd;
   slcd_pkg::shift_type           shift_res;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   // seg_on rides along for level-style writes; the mode alone selects set or clear.
   always_comb begin
      cmd         = '0;
      cmd.segment = in_segment_ff;
      case (in_mode_ff)
         slcd_pkg::MODE_SET_SEG: cmd.set_seg = 1'b1;
         slcd_pkg::MODE_CLR_SEG: cmd.clr_seg = 1'b1;
         slcd_pkg::MODE_FILL:    cmd.fill    = 1'b1;
         slcd_pkg::MODE_CLEAR:   cmd.clear   = 1'b1;
         slcd_pkg::MODE_FLUSH:   cmd.flush   = 1'b1;
         slcd_pkg::MODE_TICK:    cmd.tick    = 1'b1;
         default:                cmd.segment = in_segment_ff ^ {slcd_pkg::SEG_W{in_seg_on_ff & 1'b0}};
      endcase
   end

   assign fr_clear = csr_we && (csr_index == slcd_pkg::CSR_DISPLAY_ON) && !csr_wdata[0];

   slcd_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .cmd       (cmd),
      .shift_out (shift_res)
   );

   slcd_fr u_fr (
      .clock       (clock),
      .reset       (reset),
      .tick        (advance && cmd.tick),
      .display_on  (display_on_ff),
      .cfg_clear   (fr_clear),
      .half_period (half_period_ff),
      .fr_level    (fr_level)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         display_on_ff  <= 1'b0;
         half_period_ff <= slcd_pkg::FR_HALF_RESET;
      end else begin
         out_valid_ff <= out_valid_in;
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               slcd_pkg::CSR_DISPLAY_ON: display_on_ff  <= csr_wdata[0];
               slcd_pkg::CSR_FR_HALF:    half_period_ff <= csr_wdata[slcd_pkg::HALF_W-1:0];
               default:                  display_on_ff  <= display_on_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff    <= req_mode;
         in_segment_ff <= req_segment;
         in_seg_on_ff  <= req_seg_on;
      end
      if (advance) begin
         out_data_ff   <= shift_res.serial_data;
         out_strobe_ff <= shift_res.shift_strobe;
         out_last_ff   <= shift_res.last_bit;
         out_busy_ff   <= shift_res.busy;
         out_fr_ff     <= fr_level;
         out_disp_ff   <= display_on_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_serial_data  = out_data_ff;
   assign rsp_shift_strobe = out_strobe_ff;
   assign rsp_last_bit     = out_last_ff;
   assign rsp_fr_level     = out_fr_ff;
   assign rsp_disp_level   = out_disp_ff;
   assign rsp_busy_res     = out_busy_ff;

endmodule
